/* hdl/fasd_pkg.sv */
// Shared constants and types for the filter-above-max descending sort block.
package fasd_pkg;

  localparam int unsigned MaxItemsDef = 64;
  localparam int unsigned ValW        = 16;
  localparam int unsigned KeptCntW    = 7;
  localparam int unsigned InDataW     = 2 * ValW;
  // kept_value, threshold_max, kept_count, padded to whole bytes
  localparam int unsigned OutDataW    = ((2 * ValW + KeptCntW + 7) / 8) * 8;

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_FILT = 5'b00010,
    S_SCAN = 5'b00100,
    S_SWAP = 5'b01000,
    S_NONE = 5'b10000
  } state_e;

endpackage

/* hdl/filter_above_max_then_sort_desc_core.sv */
// Collects a set of (a, b) pairs, keeps a values above max b, emits them sorted descending.
//
// Input channel (s_axis): one (a, b) pair per item, a in tdata[15:0], b in
// tdata[31:16], tlast on the final pair of a set. Pairs load at one per cycle
// in the load state; pairs past MAX_ITEMS only add to the b maximum.
// Output channel (m_axis): one item per kept a value, largest first, carrying
// the set's b maximum and the kept count; tlast on the final one. If nothing is
// kept, a single item with tuser (none_kept) and tlast set and a zero value.
// After the last pair, a filter pass reads the a memory and writes the kept
// values to the s memory; then each selection pass scans the s memory from
// the pass index for the largest entry, one item out per pass.
// Each memory has a single read port with registered read data; no new pair
// is taken until the last result of the set sits in the output register.
// The output register holds an item while m_axis_tready is low; the sorter
// waits on it, and pair loading for the next set overlaps the final item.
// Reset empties the output register and starts a fresh set; memory contents
// are not cleared, only entries written by the current set are read.
module filter_above_max_then_sort_desc_core #(
  parameter int unsigned MAX_ITEMS = fasd_pkg::MaxItemsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fasd_pkg::InDataW-1:0]  s_axis_tdata,   // a_value, b_value
  input  logic                          s_axis_tlast,   // set_end
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [fasd_pkg::OutDataW-1:0] m_axis_tdata,   // kept_value, threshold_max, kept_count
  output logic                          m_axis_tuser,   // none_kept
  output logic                          m_axis_tlast    // run_end
);

  localparam int unsigned IdxW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned VW   = fasd_pkg::ValW;

  fasd_pkg::state_e state_q, state_d;

  logic [VW-1:0]   max_q, max_d;
  logic [CntW-1:0] cnt_q, cnt_d;     // pairs stored
  logic [CntW-1:0] fi_q, fi_d;       // filter read index
  logic [CntW-1:0] kept_q, kept_d;
  logic [CntW-1:0] pi_q, pi_d;       // selection pass
  logic [CntW-1:0] sj_q, sj_d;       // scan read index
  logic            rv_q, rv_d;       // read data valid next cycle
  logic [IdxW-1:0] ridx_q, ridx_d;
  logic [VW-1:0]   head_q, head_d;
  logic [VW-1:0]   best_q, best_d;
  logic [IdxW-1:0] bidx_q, bidx_d;

  logic            ov_q, ov_d;
  logic [VW-1:0]   o_val_q, o_val_d;
  logic [VW-1:0]   o_max_q, o_max_d;
  logic [fasd_pkg::KeptCntW-1:0] o_cnt_q, o_cnt_d;
  logic            o_none_q, o_none_d;
  logic            o_last_q, o_last_d;

  logic [VW-1:0]   a_mem [MAX_ITEMS];
  logic [VW-1:0]   s_mem [MAX_ITEMS];
  logic [VW-1:0]   a_rdata_q, s_rdata_q;
  logic            a_we, s_we;
  logic [IdxW-1:0] a_raddr, s_raddr, s_waddr;
  logic [VW-1:0]   s_wdata;

  logic [VW-1:0]   in_a, in_b;
  logic            in_acc, out_free;

  assign in_a     = s_axis_tdata[VW-1:0];
  assign in_b     = s_axis_tdata[2*VW-1:VW];
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign out_free = ~ov_q | m_axis_tready;
  assign s_axis_tready = (state_q == fasd_pkg::S_LOAD);

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[cnt_q[IdxW-1:0]] <= in_a;
    end
    a_rdata_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_mem[s_waddr] <= s_wdata;
    end
    s_rdata_q <= s_mem[s_raddr];
  end

  always_comb begin
    state_d  = state_q;
    max_d    = max_q;
    cnt_d    = cnt_q;
    fi_d     = fi_q;
    kept_d   = kept_q;
    pi_d     = pi_q;
    sj_d     = sj_q;
    rv_d     = 1'b0;
    ridx_d   = ridx_q;
    head_d   = head_q;
    best_d   = best_q;
    bidx_d   = bidx_q;
    ov_d     = ov_q & ~m_axis_tready;
    o_val_d  = o_val_q;
    o_max_d  = o_max_q;
    o_cnt_d  = o_cnt_q;
    o_none_d = o_none_q;
    o_last_d = o_last_q;
    a_we     = 1'b0;
    a_raddr  = fi_q[IdxW-1:0];
    s_we     = 1'b0;
    s_raddr  = sj_q[IdxW-1:0];
    s_waddr  = kept_q[IdxW-1:0];
    s_wdata  = a_rdata_q;

    unique case (state_q)
      fasd_pkg::S_LOAD: begin
        if (in_acc) begin
          if (in_b > max_q) begin
            max_d = in_b;
          end
          if (cnt_q < CntW'(MAX_ITEMS)) begin
            a_we  = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
          if (s_axis_tlast) begin
            fi_d    = '0;
            kept_d  = '0;
            state_d = fasd_pkg::S_FILT;
          end
        end
      end

      fasd_pkg::S_FILT: begin
        if (fi_q != cnt_q) begin
          fi_d = fi_q + 1'b1;
          rv_d = 1'b1;
        end
        if (rv_q && (a_rdata_q > max_q)) begin
          s_we   = 1'b1;
          kept_d = kept_q + 1'b1;
        end
        if (fi_q == cnt_q && !rv_q) begin
          pi_d    = '0;
          sj_d    = '0;
          state_d = (kept_q == '0) ? fasd_pkg::S_NONE : fasd_pkg::S_SCAN;
        end
      end

      fasd_pkg::S_SCAN: begin
        if (sj_q != kept_q) begin
          sj_d   = sj_q + 1'b1;
          rv_d   = 1'b1;
          ridx_d = sj_q[IdxW-1:0];
        end
        if (rv_q) begin
          // first read of a pass returns the head entry
          if (ridx_q == pi_q[IdxW-1:0]) begin
            head_d = s_rdata_q;
            best_d = s_rdata_q;
            bidx_d = ridx_q;
          end else if (s_rdata_q > best_q) begin
            best_d = s_rdata_q;
            bidx_d = ridx_q;
          end
        end
        if (sj_q == kept_q && !rv_q) begin
          state_d = fasd_pkg::S_SWAP;
        end
      end

      fasd_pkg::S_SWAP: begin
        if (out_free) begin
          s_we     = 1'b1;
          s_waddr  = bidx_q;
          s_wdata  = head_q;
          ov_d     = 1'b1;
          o_val_d  = best_q;
          o_max_d  = max_q;
          o_cnt_d  = fasd_pkg::KeptCntW'(kept_q);
          o_none_d = 1'b0;
          o_last_d = (pi_q + 1'b1 == kept_q);
          if (pi_q + 1'b1 == kept_q) begin
            max_d   = '0;
            cnt_d   = '0;
            state_d = fasd_pkg::S_LOAD;
          end else begin
            pi_d    = pi_q + 1'b1;
            sj_d    = pi_q + 1'b1;
            state_d = fasd_pkg::S_SCAN;
          end
        end
      end

      fasd_pkg::S_NONE: begin
        if (out_free) begin
          ov_d     = 1'b1;
          o_val_d  = '0;
          o_max_d  = max_q;
          o_cnt_d  = '0;
          o_none_d = 1'b1;
          o_last_d = 1'b1;
          max_d    = '0;
          cnt_d    = '0;
          state_d  = fasd_pkg::S_LOAD;
        end
      end

      default: begin
        state_d = fasd_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fasd_pkg::S_LOAD;
      max_q   <= '0;
      cnt_q   <= '0;
      fi_q    <= '0;
      kept_q  <= '0;
      pi_q    <= '0;
      sj_q    <= '0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      max_q   <= max_d;
      cnt_q   <= cnt_d;
      fi_q    <= fi_d;
      kept_q  <= kept_d;
      pi_q    <= pi_d;
      sj_q    <= sj_d;
      rv_q    <= rv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q   <= ridx_d;
    head_q   <= head_d;
    best_q   <= best_d;
    bidx_q   <= bidx_d;
    o_val_q  <= o_val_d;
    o_max_q  <= o_max_d;
    o_cnt_q  <= o_cnt_d;
    o_none_q <= o_none_d;
    o_last_q <= o_last_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = fasd_pkg::OutDataW'({o_cnt_q, o_max_q, o_val_q});
  assign m_axis_tuser  = o_none_q;
  assign m_axis_tlast  = o_last_q;

endmodule

/* hdl/fasd_checker.sv */
// Port-level checks on the result channel of the descending sort block.
module fasd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [fasd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);

  localparam int unsigned VW = fasd_pkg::ValW;
  localparam int unsigned CL = 2 * VW;
  localparam int unsigned CH = 2 * VW + fasd_pkg::KeptCntW - 1;

  // a stalled item holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  // an empty set ends its run in one item
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("none_kept item without run_end");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[VW-1:0] == '0) && (m_axis_tdata[CH:CL] == '0))
    else $error("none_kept item with nonzero value or count");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      (m_axis_tdata[CH:CL] != '0) && (m_axis_tdata[VW-1:0] > m_axis_tdata[CL-1:VW]))
    else $error("kept item not above threshold or with zero count");

endmodule

bind filter_above_max_then_sort_desc_core fasd_checker u_fasd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
